// ----- rtl/edc_pkg.sv -----
// edc_pkg: shared constants, tables and sideband types for the equirectangular
// distance core. No dependencies.
package edc_pkg;

  localparam int ANGLE_FRAC_BITS = 22;
  localparam int CORDIC_STAGES   = 24;

  localparam logic [23:0] KM_RESET = 24'd7294157;   // 111.3 km, Q8.16

  localparam int LAT_LIM = 90 * (1 << ANGLE_FRAC_BITS);
  localparam int LON_LIM = 180 * (1 << ANGLE_FRAC_BITS);

  // |mean latitude| and |difference| widths over the valid range
  localparam int MAG_W  = ANGLE_FRAC_BITS + 7;
  localparam int DLAT_W = ANGLE_FRAC_BITS + 8;
  localparam int DLON_W = ANGLE_FRAC_BITS + 9;
  localparam int PDY_W  = DLAT_W + 24;
  localparam int PDX_W  = DLON_W + 24;
  localparam int DY_W   = 32;
  localparam int DXK_W  = 33;

  // angle = mean * 2^(32-F) / 360 = mean * 2^SH / 45
  localparam int SH        = 29 - ANGLE_FRAC_BITS;
  localparam int DIV_K1    = MAG_W + 7;
  localparam int M1_W      = DIV_K1 - 5;
  localparam logic [63:0] DIV_M1 = ((64'd1 << DIV_K1) + 64'd44) / 64'd45;
  localparam int Q_W       = MAG_W - 5;
  localparam int R_W       = 6;
  localparam int DIV_K2    = 28;
  localparam int M2_W      = 23;
  localparam logic [63:0] DIV_M2 = ((64'd1 << DIV_K2) + 64'd44) / 64'd45;

  // CORDIC datapath
  localparam int CW = 34;
  localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sd652032874;
  localparam logic signed [CW-1:0] ONE_Q30     = 34'sd1073741824;

  localparam logic [31:0] ATAN_TURNS [32] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
    32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163,
    32'd81, 32'd41, 32'd20, 32'd10, 32'd5, 32'd3, 32'd1, 32'd1, 32'd0
  };

  localparam int SQRT_STAGES = 32;

  // fixed transaction latency, start to out_valid
  localparam int LATENCY = 7 + CORDIC_STAGES + 1 + 3 + SQRT_STAGES + 1;

  typedef struct packed {
    logic             err;
    logic [DY_W-1:0]  dy;
    logic [DXK_W-1:0] dxk;
  } edc_side_t;

  typedef struct packed {
    logic err;
    logic sat;
  } edc_flag_t;

endpackage

// ----- rtl/edc_cordic.sv -----
// edc_cordic: pipelined rotation-mode CORDIC, one iteration per stage, cosine out.
// Depends on edc_pkg.
module edc_cordic (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_vld,
  input  logic signed [31:0]             in_angle,
  input  edc_pkg::edc_side_t             in_side,
  output logic                           out_vld,
  output logic [30:0]                    out_cos,
  output edc_pkg::edc_side_t             out_side
);

  localparam int N  = edc_pkg::CORDIC_STAGES;
  localparam int CW = edc_pkg::CW;

  logic signed [CW-1:0] x_in [N];
  logic signed [CW-1:0] y_in [N];
  logic signed [CW-1:0] z_in [N];
  logic                 v_in [N];
  edc_pkg::edc_side_t   s_in [N];

  logic signed [CW-1:0] x_r [N];
  logic signed [CW-1:0] y_r [N];
  logic signed [CW-1:0] z_r [N];
  logic                 v_r [N];
  edc_pkg::edc_side_t   s_r [N];

  assign x_in[0] = edc_pkg::CORDIC_GAIN;
  assign y_in[0] = '0;
  assign z_in[0] = CW'(in_angle);
  assign v_in[0] = in_vld;
  assign s_in[0] = in_side;

  for (genvar i = 0; i < N; i++) begin : g_stage
    logic signed [CW-1:0] xs;
    logic signed [CW-1:0] ys;
    logic signed [CW-1:0] at;

    if (i > 0) begin : g_link
      assign x_in[i] = x_r[i-1];
      assign y_in[i] = y_r[i-1];
      assign z_in[i] = z_r[i-1];
      assign v_in[i] = v_r[i-1];
      assign s_in[i] = s_r[i-1];
    end

    assign xs = x_in[i] >>> i;
    assign ys = y_in[i] >>> i;
    assign at = $signed({{(CW-32){1'b0}}, edc_pkg::ATAN_TURNS[i]});

    always_ff @(posedge clk) begin
      if (!z_in[i][CW-1]) begin
        x_r[i] <= x_in[i] - ys;
        y_r[i] <= y_in[i] + xs;
        z_r[i] <= z_in[i] - at;
      end else begin
        x_r[i] <= x_in[i] + ys;
        y_r[i] <= y_in[i] - xs;
        z_r[i] <= z_in[i] + at;
      end
      s_r[i] <= s_in[i];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i] <= 1'b0;
      end else begin
        v_r[i] <= v_in[i];
      end
    end
  end

  // clamp to [0, 1.0] in Q1.30
  logic [30:0] cos_nxt;
  logic [30:0] cos_r;
  logic        vld_r;
  edc_pkg::edc_side_t side_r;

  always_comb begin
    if (x_r[N-1][CW-1]) begin
      cos_nxt = '0;
    end else if (x_r[N-1] > edc_pkg::ONE_Q30) begin
      cos_nxt = 31'h4000_0000;
    end else begin
      cos_nxt = x_r[N-1][30:0];
    end
  end

  always_ff @(posedge clk) begin
    cos_r  <= cos_nxt;
    side_r <= s_r[N-1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= v_r[N-1];
    end
  end

  assign out_vld  = vld_r;
  assign out_cos  = cos_r;
  assign out_side = side_r;

endmodule

// ----- rtl/edc_isqrt.sv -----
// edc_isqrt: pipelined restoring integer square root, 64-bit radicand, one
// result bit per stage. Depends on edc_pkg.
module edc_isqrt (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_vld,
  input  logic [63:0]        in_rad,
  input  edc_pkg::edc_flag_t in_flag,
  output logic               out_vld,
  output logic [31:0]        out_root,
  output edc_pkg::edc_flag_t out_flag
);

  localparam int N = edc_pkg::SQRT_STAGES;

  logic [63:0]        v_in   [N];
  logic [63:0]        res_in [N];
  logic               vl_in  [N];
  edc_pkg::edc_flag_t f_in   [N];

  logic [63:0]        v_r   [N];
  logic [63:0]        res_r [N];
  logic               vl_r  [N];
  edc_pkg::edc_flag_t f_r   [N];

  assign v_in[0]   = in_rad;
  assign res_in[0] = '0;
  assign vl_in[0]  = in_vld;
  assign f_in[0]   = in_flag;

  for (genvar i = 0; i < N; i++) begin : g_stage
    localparam logic [63:0] BIT = 64'd1 << (62 - 2 * i);
    logic [63:0] trial;

    if (i > 0) begin : g_link
      assign v_in[i]   = v_r[i-1];
      assign res_in[i] = res_r[i-1];
      assign vl_in[i]  = vl_r[i-1];
      assign f_in[i]   = f_r[i-1];
    end

    assign trial = res_in[i] + BIT;

    always_ff @(posedge clk) begin
      if (v_in[i] >= trial) begin
        v_r[i]   <= v_in[i] - trial;
        res_r[i] <= (res_in[i] >> 1) + BIT;
      end else begin
        v_r[i]   <= v_in[i];
        res_r[i] <= res_in[i] >> 1;
      end
      f_r[i] <= f_in[i];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vl_r[i] <= 1'b0;
      end else begin
        vl_r[i] <= vl_in[i];
      end
    end
  end

  assign out_vld  = vl_r[N-1];
  assign out_root = res_r[N-1][31:0];
  assign out_flag = f_r[N-1];

endmodule

// ----- rtl/equirectangular_distance_core.sv -----
// equirectangular_distance_core: top level of the flat-earth distance pipeline.
// Depends on edc_pkg, edc_cordic and edc_isqrt.
//
// Fully pipelined: a transaction is taken on every cycle that start is high
// (busy is never raised). Its result sits on out_range_distance /
// out_coordinate_error with a one-cycle out_valid strobe once it has passed
// 7 front-end stages for the range check, mean latitude and the divide by
// 360, one stage per CORDIC iteration (24 by default) plus a clamp, 3 for
// the multiplies and the sum of squares, one per root bit in the 32-stage
// square root, and the output register. The receiver cannot stall the
// block, so results must be taken as they come. cfg_wr_data reloads the
// km-per-degree scale (Q8.16); change it only while no transaction is in
// flight.
module equirectangular_distance_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] in_from_latitude,
  input  logic [31:0] in_from_longitude,
  input  logic [31:0] in_to_latitude,
  input  logic [31:0] in_to_longitude,
  input  logic        cfg_wr_en,
  input  logic [23:0] cfg_wr_data,
  output logic        out_valid,
  output logic [31:0] out_range_distance,
  output logic        out_coordinate_error
);

  localparam int F = edc_pkg::ANGLE_FRAC_BITS;

  // never stalls
  assign busy = 1'b0;

  // scale register
  logic [23:0] km_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      km_r <= edc_pkg::KM_RESET;
    end else if (cfg_wr_en) begin
      km_r <= cfg_wr_data;
    end
  end

  // valid chain for the front end (S0..S6)
  logic [6:0] v_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= {v_r[5:0], start};
    end
  end

  // S0: input capture
  logic signed [31:0] s0_flat_r, s0_flon_r, s0_tlat_r, s0_tlon_r;
  always_ff @(posedge clk) begin
    s0_flat_r <= in_from_latitude;
    s0_flon_r <= in_from_longitude;
    s0_tlat_r <= in_to_latitude;
    s0_tlon_r <= in_to_longitude;
  end

  // S1: range check, floor mean latitude, signed differences
  logic               s1_err_nxt;
  logic signed [32:0] s1_sum;
  logic               s1_err_r;
  logic signed [31:0] s1_mean_r;
  logic signed [32:0] s1_dlat_r, s1_dlon_r;

  always_comb begin
    s1_err_nxt = (s0_flat_r < -edc_pkg::LAT_LIM) || (s0_flat_r > edc_pkg::LAT_LIM) ||
                 (s0_tlat_r < -edc_pkg::LAT_LIM) || (s0_tlat_r > edc_pkg::LAT_LIM) ||
                 (s0_flon_r < -edc_pkg::LON_LIM) || (s0_flon_r > edc_pkg::LON_LIM) ||
                 (s0_tlon_r < -edc_pkg::LON_LIM) || (s0_tlon_r > edc_pkg::LON_LIM);
    s1_sum = 33'(s0_flat_r) + 33'(s0_tlat_r);
  end

  always_ff @(posedge clk) begin
    s1_err_r  <= s1_err_nxt;
    s1_mean_r <= 32'(s1_sum >>> 1);
    s1_dlat_r <= 33'(s0_flat_r) - 33'(s0_tlat_r);
    s1_dlon_r <= 33'(s0_flon_r) - 33'(s0_tlon_r);
  end

  // S2: magnitudes
  logic [31:0] s2_mean_abs;
  logic [32:0] s2_dlat_abs, s2_dlon_abs;
  logic                        s2_err_r, s2_neg_r;
  logic [edc_pkg::MAG_W-1:0]   s2_mag_r;
  logic [edc_pkg::DLAT_W-1:0]  s2_adlat_r;
  logic [edc_pkg::DLON_W-1:0]  s2_adlon_r;

  always_comb begin
    s2_mean_abs = s1_mean_r[31] ? (~s1_mean_r + 32'd1) : s1_mean_r;
    s2_dlat_abs = s1_dlat_r[32] ? (~s1_dlat_r + 33'd1) : s1_dlat_r;
    s2_dlon_abs = s1_dlon_r[32] ? (~s1_dlon_r + 33'd1) : s1_dlon_r;
  end

  always_ff @(posedge clk) begin
    s2_err_r   <= s1_err_r;
    s2_neg_r   <= s1_mean_r[31];
    s2_mag_r   <= s2_mean_abs[edc_pkg::MAG_W-1:0];
    s2_adlat_r <= s2_dlat_abs[edc_pkg::DLAT_W-1:0];
    s2_adlon_r <= s2_dlon_abs[edc_pkg::DLON_W-1:0];
  end

  // S3: quotient by 45 via reciprocal, scale the differences
  logic [edc_pkg::MAG_W+edc_pkg::M1_W-1:0] s3_qprod;
  logic                        s3_err_r, s3_neg_r;
  logic [edc_pkg::MAG_W-1:0]   s3_mag_r;
  logic [edc_pkg::Q_W-1:0]     s3_q_r;
  logic [edc_pkg::PDY_W-1:0]   s3_pdy_r;
  logic [edc_pkg::PDX_W-1:0]   s3_pdx_r;

  assign s3_qprod = (edc_pkg::MAG_W + edc_pkg::M1_W)'(s2_mag_r) *
                    (edc_pkg::MAG_W + edc_pkg::M1_W)'(edc_pkg::DIV_M1[edc_pkg::M1_W-1:0]);

  always_ff @(posedge clk) begin
    s3_err_r <= s2_err_r;
    s3_neg_r <= s2_neg_r;
    s3_mag_r <= s2_mag_r;
    s3_q_r   <= s3_qprod[edc_pkg::DIV_K1 +: edc_pkg::Q_W];
    s3_pdy_r <= edc_pkg::PDY_W'(s2_adlat_r) * edc_pkg::PDY_W'(km_r);
    s3_pdx_r <= edc_pkg::PDX_W'(s2_adlon_r) * edc_pkg::PDX_W'(km_r);
  end

  // S4: remainder by 45
  logic [edc_pkg::MAG_W-1:0]  s4_rem;
  logic                       s4_neg_r;
  logic [edc_pkg::Q_W-1:0]    s4_q_r;
  logic [edc_pkg::R_W-1:0]    s4_r_r;
  edc_pkg::edc_side_t         s4_side_r;

  assign s4_rem = s3_mag_r - edc_pkg::MAG_W'(s3_q_r) * edc_pkg::MAG_W'(45);

  always_ff @(posedge clk) begin
    s4_neg_r      <= s3_neg_r;
    s4_q_r        <= s3_q_r;
    s4_r_r        <= s4_rem[edc_pkg::R_W-1:0];
    s4_side_r.err <= s3_err_r;
    s4_side_r.dy  <= s3_pdy_r[F +: edc_pkg::DY_W];
    s4_side_r.dxk <= s3_pdx_r[F +: edc_pkg::DXK_W];
  end

  // S5: fractional part of the binary angle, floor(r * 2^SH / 45)
  localparam int TP_W = edc_pkg::R_W + edc_pkg::SH + edc_pkg::M2_W;
  logic [TP_W-1:0]            s5_tprod;
  logic                       s5_neg_r;
  logic [edc_pkg::Q_W-1:0]    s5_q_r;
  logic [edc_pkg::SH-1:0]     s5_t_r;
  edc_pkg::edc_side_t         s5_side_r;

  assign s5_tprod = TP_W'({s4_r_r, {edc_pkg::SH{1'b0}}}) *
                    TP_W'(edc_pkg::DIV_M2[edc_pkg::M2_W-1:0]);

  always_ff @(posedge clk) begin
    s5_neg_r  <= s4_neg_r;
    s5_q_r    <= s4_q_r;
    s5_t_r    <= s5_tprod[edc_pkg::DIV_K2 +: edc_pkg::SH];
    s5_side_r <= s4_side_r;
  end

  // S6: signed binary angle (2^32 per turn)
  logic [31:0]        s6_amag;
  logic signed [31:0] s6_angle_r;
  edc_pkg::edc_side_t s6_side_r;

  assign s6_amag = 32'({s5_q_r, s5_t_r});

  always_ff @(posedge clk) begin
    s6_angle_r <= s5_neg_r ? $signed(~s6_amag + 32'd1) : $signed(s6_amag);
    s6_side_r  <= s5_side_r;
  end

  // cosine of the mean latitude
  logic               c_vld;
  logic [30:0]        c_cos;
  edc_pkg::edc_side_t c_side;

  edc_cordic u_cordic (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (v_r[6]),
    .in_angle (s6_angle_r),
    .in_side  (s6_side_r),
    .out_vld  (c_vld),
    .out_cos  (c_cos),
    .out_side (c_side)
  );

  // P1: dx = dxk * cos
  logic [63:0]              p1_prod;
  logic                     p1_vld_r, p1_err_r;
  logic [32:0]              p1_dx_r;
  logic [edc_pkg::DY_W-1:0] p1_dy_r;

  assign p1_prod = 64'(c_side.dxk) * 64'(c_cos);

  always_ff @(posedge clk) begin
    p1_err_r <= c_side.err;
    p1_dx_r  <= p1_prod[30 +: 33];
    p1_dy_r  <= c_side.dy;
  end

  // P2: squares
  logic        p2_vld_r, p2_err_r, p2_sat_r;
  logic [63:0] p2_sqx_r, p2_sqy_r;

  always_ff @(posedge clk) begin
    p2_err_r <= p1_err_r;
    p2_sat_r <= p1_dx_r[32];
    p2_sqx_r <= 64'(p1_dx_r[31:0]) * 64'(p1_dx_r[31:0]);
    p2_sqy_r <= 64'(p1_dy_r) * 64'(p1_dy_r);
  end

  // P3: sum of squares, overflow flags saturation
  logic [64:0]        p3_sum;
  logic               p3_vld_r;
  logic [63:0]        p3_rad_r;
  edc_pkg::edc_flag_t p3_flag_r;

  assign p3_sum = {1'b0, p2_sqx_r} + {1'b0, p2_sqy_r};

  always_ff @(posedge clk) begin
    p3_rad_r      <= p3_sum[63:0];
    p3_flag_r.err <= p2_err_r;
    p3_flag_r.sat <= p2_sat_r | p3_sum[64];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_vld_r <= 1'b0;
      p2_vld_r <= 1'b0;
      p3_vld_r <= 1'b0;
    end else begin
      p1_vld_r <= c_vld;
      p2_vld_r <= p1_vld_r;
      p3_vld_r <= p2_vld_r;
    end
  end

  // root
  logic               q_vld;
  logic [31:0]        q_root;
  edc_pkg::edc_flag_t q_flag;

  edc_isqrt u_isqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (p3_vld_r),
    .in_rad   (p3_rad_r),
    .in_flag  (p3_flag_r),
    .out_vld  (q_vld),
    .out_root (q_root),
    .out_flag (q_flag)
  );

  // output register: error forces zero, overflow saturates
  logic        out_vld_r;
  logic [31:0] out_dist_r, out_dist_nxt;
  logic        out_err_r;

  always_comb begin
    priority if (q_flag.err) begin
      out_dist_nxt = '0;
    end else if (q_flag.sat) begin
      out_dist_nxt = '1;
    end else begin
      out_dist_nxt = q_root;
    end
  end

  always_ff @(posedge clk) begin
    out_dist_r <= out_dist_nxt;
    out_err_r  <= q_flag.err;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= q_vld;
    end
  end

  assign out_valid            = out_vld_r;
  assign out_range_distance   = out_dist_r;
  assign out_coordinate_error = out_err_r;

  // checks
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_coordinate_error |-> out_range_distance == 32'd0)
    else $error("error transaction with non-zero distance");

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start, edc_pkg::LATENCY))
    else $error("result without a matching transaction");

  a_cos_range: assert property (@(posedge clk) disable iff (!rst_n)
    c_vld |-> c_cos <= 31'h4000_0000)
    else $error("cosine above one");

  a_sat_out: assert property (@(posedge clk) disable iff (!rst_n)
    q_vld && q_flag.sat && !q_flag.err |=> out_valid && out_range_distance == 32'hFFFF_FFFF)
    else $error("overflow transaction not saturated");

endmodule
